@@ src/dwg_pkg.sv @@
`timescale 1ns / 1ps

package dwg_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_SIZE_W = 9;
    localparam int COEF_W     = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_ROWS = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_COLS = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_KEEP = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_GAIN = 4'd3;

    localparam logic [CFG_SIZE_W-1:0] ROWS_RESET = 9'd200;
    localparam logic [CFG_SIZE_W-1:0] COLS_RESET = 9'd200;
    localparam logic [COEF_W-1:0]     KEEP_RESET = 16'd32440;
    localparam logic [COEF_W-1:0]     GAIN_RESET = 16'd16056;

    localparam int MIN_SIZE = 3;

    // result index fields
    localparam int IDX_W = 8;

    // result queue
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;

    // Q1.15 rounding
    localparam int FRAC_SHIFT = 15;
    localparam int ROUND_HALF = 16384;

    // per-transaction bookkeeping that rides along with the datapath
    typedef struct packed {
        logic             emit;      // input produces at least one result
        logic             dual;      // last-row input, produces two results
        logic             zero;      // first result lies on the border
        logic             last_col;  // input sits on the last column
        logic [IDX_W-1:0] row;       // row of the input cell
        logic [IDX_W-1:0] col;       // column of the input cell
    } dwg_tag_t;

endpackage

@@ src/dwg_line_store.sv @@
`timescale 1ns / 1ps

module dwg_line_store import dwg_pkg::*; #(
    parameter int HEIGHT_BITS = 24,
    parameter int MAX_COLS    = 256,
    parameter int ADDR_W      = $clog2(MAX_COLS)
) (
    input  logic                          aclk,
    input  logic                          accept,
    input  logic [ADDR_W-1:0]             wr_addr,
    input  logic [ADDR_W-1:0]             above_rd_addr,
    input  logic signed [HEIGHT_BITS-1:0] cur_h,
    input  logic signed [HEIGHT_BITS-1:0] prev_h,
    output logic signed [HEIGHT_BITS-1:0] above_q,
    output logic signed [HEIGHT_BITS-1:0] up_q,
    output logic signed [HEIGHT_BITS-1:0] prev_q
);

    logic signed [HEIGHT_BITS-1:0] above_mem [MAX_COLS];
    logic signed [HEIGHT_BITS-1:0] two_mem   [MAX_COLS];
    logic signed [HEIGHT_BITS-1:0] prev_mem  [MAX_COLS];

    // above_q holds the center cell when accept rises; it is written into
    // the two-above line before it is refreshed with the right neighbor.
    always_ff @(posedge aclk) begin
        if (accept) begin
            above_mem[wr_addr] <= cur_h;
            above_q            <= above_mem[above_rd_addr];
        end
    end

    // read and write at the same column: old data comes out
    always_ff @(posedge aclk) begin
        if (accept) begin
            two_mem[wr_addr] <= above_q;
            up_q             <= two_mem[wr_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            prev_mem[wr_addr] <= prev_h;
            prev_q            <= prev_mem[wr_addr];
        end
    end

endmodule

@@ src/dwg_stencil_calc.sv @@
`timescale 1ns / 1ps

module dwg_stencil_calc import dwg_pkg::*; #(
    parameter int HEIGHT_BITS = 24
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          accept,
    input  dwg_tag_t                      in_tag,
    input  logic signed [HEIGHT_BITS-1:0] cur_h,
    input  logic signed [HEIGHT_BITS-1:0] above_q,
    input  logic signed [HEIGHT_BITS-1:0] up_q,
    input  logic signed [HEIGHT_BITS-1:0] prev_q,
    input  logic [COEF_W-1:0]             keep_factor,
    input  logic [COEF_W-1:0]             wave_gain,
    output logic                          res_valid,
    output logic signed [HEIGHT_BITS-1:0] res_height,
    output dwg_tag_t                      res_tag,
    output logic [1:0]                    pend_cnt
);

    localparam int TWO_W = HEIGHT_BITS + 2;
    localparam int LAP_W = HEIGHT_BITS + 4;
    localparam int PK_W  = TWO_W + COEF_W + 1;
    localparam int PG_W  = LAP_W + COEF_W + 1;
    localparam int ACC_W = PG_W + 1;
    localparam int SH_W  = ACC_W - FRAC_SHIFT;
    localparam logic signed [ACC_W-1:0] RND = ACC_W'(ROUND_HALF);

    // stage 1: window capture
    logic                          s1_valid_reg;
    dwg_tag_t                      s1_tag_reg;
    logic signed [HEIGHT_BITS-1:0] s1_h_reg, s1_center_reg, s1_left_reg;
    logic signed [HEIGHT_BITS-1:0] win_left_reg;

    // stage 2: sums
    logic                          s2_valid_reg;
    dwg_tag_t                      s2_tag_reg;
    logic signed [TWO_W-1:0]       s2_two_reg, two_next;
    logic signed [LAP_W-1:0]       s2_lap_reg, lap_next;

    // stage 3: products
    logic                          s3_valid_reg;
    dwg_tag_t                      s3_tag_reg;
    logic signed [PK_W-1:0]        s3_pk_reg, pk_next;
    logic signed [PG_W-1:0]        s3_pg_reg, pg_next;

    logic signed [COEF_W:0]        keep_s, gain_s;
    logic signed [ACC_W-1:0]       acc;
    logic signed [SH_W-1:0]        sh;
    logic                          fits;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_tag_reg    <= in_tag;
            s1_h_reg      <= cur_h;
            s1_center_reg <= above_q;
            s1_left_reg   <= win_left_reg;
            win_left_reg  <= above_q;
        end
        s2_tag_reg <= s1_tag_reg;
        s2_two_reg <= two_next;
        s2_lap_reg <= lap_next;
        s3_tag_reg <= s2_tag_reg;
        s3_pk_reg  <= pk_next;
        s3_pg_reg  <= pg_next;
    end

    // above_q now carries the right neighbor
    always_comb begin
        two_next = (TWO_W'(s1_center_reg) <<< 1) - TWO_W'(prev_q);
        lap_next = LAP_W'(up_q) + LAP_W'(s1_h_reg) + LAP_W'(s1_left_reg)
                 + LAP_W'(above_q) - (LAP_W'(s1_center_reg) <<< 2);
    end

    assign keep_s  = $signed({1'b0, keep_factor});
    assign gain_s  = $signed({1'b0, wave_gain});
    assign pk_next = keep_s * s2_two_reg;
    assign pg_next = gain_s * s2_lap_reg;

    always_comb begin
        acc  = ACC_W'(s3_pk_reg) + ACC_W'(s3_pg_reg) + RND;
        sh   = SH_W'(acc >>> FRAC_SHIFT);
        fits = (&sh[SH_W-1:HEIGHT_BITS-1]) | ~(|sh[SH_W-1:HEIGHT_BITS-1]);
        if (s3_tag_reg.zero) begin
            res_height = '0;
        end else if (fits) begin
            res_height = sh[HEIGHT_BITS-1:0];
        end else begin
            res_height = {sh[SH_W-1], {(HEIGHT_BITS-1){~sh[SH_W-1]}}};
        end
    end

    assign res_valid = s3_valid_reg & s3_tag_reg.emit;
    assign res_tag   = s3_tag_reg;
    assign pend_cnt  = 2'(s1_valid_reg & s1_tag_reg.emit)
                     + 2'(s2_valid_reg & s2_tag_reg.emit)
                     + 2'(s3_valid_reg & s3_tag_reg.emit);

endmodule

@@ src/dwg_result_fifo.sv @@
`timescale 1ns / 1ps

module dwg_result_fifo import dwg_pkg::*; #(
    parameter int HEIGHT_BITS = 24
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          push,
    input  logic signed [HEIGHT_BITS-1:0] push_height,
    input  dwg_tag_t                      push_tag,
    output logic [FIFO_AW:0]              fill,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [HEIGHT_BITS-1:0] m_next_height,
    output logic [IDX_W-1:0]              m_out_row,
    output logic [IDX_W-1:0]              m_out_col,
    output logic                          m_run_last,
    output logic                          m_frame_done
);

    logic signed [HEIGHT_BITS-1:0] height_mem [FIFO_DEPTH];
    dwg_tag_t                      tag_mem    [FIFO_DEPTH];

    logic [FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_AW:0]   cnt_reg;
    logic               phase_reg;
    dwg_tag_t           head;
    logic               xfer, pop;

    assign head    = tag_mem[rd_ptr_reg];
    assign m_valid = (cnt_reg != '0);
    assign xfer    = m_valid & m_ready;
    assign pop     = xfer & (~head.dual | phase_reg);
    assign fill    = cnt_reg;

    always_ff @(posedge aclk) begin
        if (push) begin
            height_mem[wr_ptr_reg] <= push_height;
            tag_mem[wr_ptr_reg]    <= push_tag;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
            phase_reg  <= 1'b0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
            if (xfer) begin
                phase_reg <= head.dual & ~phase_reg;
            end
        end
    end

    // a last-row entry unpacks into the cell above, then its own border cell
    always_comb begin
        if (phase_reg) begin
            m_next_height = '0;
            m_out_row     = head.row;
            m_run_last    = 1'b1;
            m_frame_done  = head.last_col;
        end else begin
            m_next_height = height_mem[rd_ptr_reg];
            m_out_row     = head.row - 1'b1;
            m_run_last    = ~head.dual;
            m_frame_done  = 1'b0;
        end
        m_out_col = head.col;
    end

endmodule

@@ src/damped_wave_grid_stencil.sv @@
`timescale 1ns / 1ps
// Channel   | Direction | Handshake            | Payload
// ----------+-----------+----------------------+-------------------------------------------
// s_        | in        | s_valid / s_ready    | s_cur_height, s_prev_height
// m_        | out       | m_valid / m_ready    | m_next_height, m_out_row, m_out_col,
//           |           |                      | m_run_last, m_frame_done
// cfg_      | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One cell transaction per clock while s_ready is high; results pass the window, sums
// and products stages, then an eight-entry queue, to m_. Last-row cells give two results,
// so on the last row the single result port, not the input, sets the pace.
// Reset clears counters, pipeline valids and the queue; line stores start unwritten
// and need no clearing pass. s_ready drops only when queue plus pipeline would fill.

module damped_wave_grid_stencil import dwg_pkg::*; #(
    parameter int MAX_ROWS    = 256,
    parameter int MAX_COLS    = 256,
    parameter int HEIGHT_BITS = 24
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [HEIGHT_BITS-1:0] s_cur_height,
    input  logic signed [HEIGHT_BITS-1:0] s_prev_height,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [HEIGHT_BITS-1:0] m_next_height,
    output logic [IDX_W-1:0]              m_out_row,
    output logic [IDX_W-1:0]              m_out_col,
    output logic                          m_run_last,
    output logic                          m_frame_done,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data
);

    localparam int CA_W   = $clog2(MAX_COLS);
    localparam int RA_W   = $clog2(MAX_ROWS);
    localparam int CSZ_W  = ($clog2(MAX_COLS+1) > CFG_SIZE_W) ? $clog2(MAX_COLS+1) : CFG_SIZE_W;
    localparam int RSZ_W  = ($clog2(MAX_ROWS+1) > CFG_SIZE_W) ? $clog2(MAX_ROWS+1) : CFG_SIZE_W;
    localparam logic [CSZ_W-1:0] COLS_MAX = CSZ_W'(MAX_COLS);
    localparam logic [RSZ_W-1:0] ROWS_MAX = RSZ_W'(MAX_ROWS);
    localparam logic [CSZ_W-1:0] COLS_MIN = CSZ_W'(MIN_SIZE);
    localparam logic [RSZ_W-1:0] ROWS_MIN = RSZ_W'(MIN_SIZE);

    // configuration registers
    logic [CFG_SIZE_W-1:0] rows_reg, cols_reg;
    logic [COEF_W-1:0]     keep_reg, gain_reg;

    // raster position of the next input
    logic [RA_W-1:0] row_cnt_reg;
    logic [CA_W-1:0] col_cnt_reg;

    logic [CSZ_W-1:0] cols_raw, cols_eff;
    logic [RSZ_W-1:0] rows_raw, rows_eff;
    logic             last_col, last_row, accept;
    logic [CA_W-1:0]  above_rd_addr;
    logic [31:0]      row_wide, col_wide;
    dwg_tag_t         in_tag;

    logic signed [HEIGHT_BITS-1:0] above_q, up_q, prev_q;
    logic                          res_valid;
    logic signed [HEIGHT_BITS-1:0] res_height;
    dwg_tag_t                      res_tag;
    logic [1:0]                    pend_cnt;
    logic [FIFO_AW:0]              fifo_fill;
    logic [FIFO_AW+1:0]            inflight;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg <= ROWS_RESET;
            cols_reg <= COLS_RESET;
            keep_reg <= KEEP_RESET;
            gain_reg <= GAIN_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_IDX_ROWS: rows_reg <= cfg_data[CFG_SIZE_W-1:0];
                CFG_IDX_COLS: cols_reg <= cfg_data[CFG_SIZE_W-1:0];
                CFG_IDX_KEEP: keep_reg <= cfg_data[COEF_W-1:0];
                CFG_IDX_GAIN: gain_reg <= cfg_data[COEF_W-1:0];
                default: ;
            endcase
        end
    end

    // sizes clamp to [3, MAX]
    always_comb begin
        cols_raw = CSZ_W'(cols_reg);
        rows_raw = RSZ_W'(rows_reg);
        if (cols_raw < COLS_MIN) begin
            cols_eff = COLS_MIN;
        end else if (cols_raw > COLS_MAX) begin
            cols_eff = COLS_MAX;
        end else begin
            cols_eff = cols_raw;
        end
        if (rows_raw < ROWS_MIN) begin
            rows_eff = ROWS_MIN;
        end else if (rows_raw > ROWS_MAX) begin
            rows_eff = ROWS_MAX;
        end else begin
            rows_eff = rows_raw;
        end
    end

    // counters at or past the last index count as the last index
    assign last_col = CSZ_W'(col_cnt_reg) >= (cols_eff - 1'b1);
    assign last_row = RSZ_W'(row_cnt_reg) >= (rows_eff - 1'b1);

    // admit only if every transaction in flight still finds a queue slot
    assign inflight = (FIFO_AW+2)'(fifo_fill) + (FIFO_AW+2)'(pend_cnt);
    assign s_ready  = inflight < (FIFO_AW+2)'(FIFO_DEPTH);
    assign accept   = s_valid & s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_cnt_reg <= '0;
            col_cnt_reg <= '0;
        end else if (accept) begin
            if (last_col) begin
                col_cnt_reg <= '0;
                row_cnt_reg <= last_row ? '0 : row_cnt_reg + 1'b1;
            end else begin
                col_cnt_reg <= col_cnt_reg + 1'b1;
            end
        end
    end

    // Fetch the right neighbor; it doubles as the next center. On the last
    // column, fetch column 0 for the start of the next row.
    assign above_rd_addr = last_col ? '0 : col_cnt_reg + 1'b1;

    always_comb begin
        row_wide        = 32'(row_cnt_reg);
        col_wide        = 32'(col_cnt_reg);
        in_tag.emit     = (row_cnt_reg != '0);
        in_tag.dual     = last_row & (row_cnt_reg != '0);
        in_tag.zero     = (row_cnt_reg <= RA_W'(1)) | (col_cnt_reg == '0) | last_col;
        in_tag.last_col = last_col;
        in_tag.row      = row_wide[IDX_W-1:0];
        in_tag.col      = col_wide[IDX_W-1:0];
    end

    dwg_line_store #(
        .HEIGHT_BITS (HEIGHT_BITS),
        .MAX_COLS    (MAX_COLS),
        .ADDR_W      (CA_W)
    ) u_line_store (
        .aclk          (aclk),
        .accept        (accept),
        .wr_addr       (col_cnt_reg),
        .above_rd_addr (above_rd_addr),
        .cur_h         (s_cur_height),
        .prev_h        (s_prev_height),
        .above_q       (above_q),
        .up_q          (up_q),
        .prev_q        (prev_q)
    );

    dwg_stencil_calc #(
        .HEIGHT_BITS (HEIGHT_BITS)
    ) u_calc (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .in_tag      (in_tag),
        .cur_h       (s_cur_height),
        .above_q     (above_q),
        .up_q        (up_q),
        .prev_q      (prev_q),
        .keep_factor (keep_reg),
        .wave_gain   (gain_reg),
        .res_valid   (res_valid),
        .res_height  (res_height),
        .res_tag     (res_tag),
        .pend_cnt    (pend_cnt)
    );

    dwg_result_fifo #(
        .HEIGHT_BITS (HEIGHT_BITS)
    ) u_fifo (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .push          (res_valid),
        .push_height   (res_height),
        .push_tag      (res_tag),
        .fill          (fifo_fill),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_next_height (m_next_height),
        .m_out_row     (m_out_row),
        .m_out_col     (m_out_col),
        .m_run_last    (m_run_last),
        .m_frame_done  (m_frame_done)
    );

endmodule

@@ src/dwg_checker.sv @@
`timescale 1ns / 1ps

module dwg_checker import dwg_pkg::*; #(
    parameter int HEIGHT_BITS = 24
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic signed [HEIGHT_BITS-1:0] m_next_height,
    input logic [IDX_W-1:0]              m_out_row,
    input logic [IDX_W-1:0]              m_out_col,
    input logic                          m_run_last,
    input logic                          m_frame_done
);

    // the frame closes on the last result of its input
    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_done |-> m_run_last)
        else $error("frame_done without run_last");

    // the closing cell sits on the border
    a_done_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_done |-> m_next_height == '0)
        else $error("frame_done on a nonzero height");

    a_col0_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_out_col == '0 |-> m_next_height == '0)
        else $error("column 0 result not zero");

    // the second result of a pair is ready at once, one row further down
    a_pair_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_run_last |=>
            m_valid && m_out_row == $past(m_out_row) + 1'b1
            && m_out_col == $past(m_out_col))
        else $error("second result of a pair missing");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_next_height)
            && $stable(m_out_row) && $stable(m_out_col))
        else $error("result changed while stalled");

endmodule

bind damped_wave_grid_stencil dwg_checker #(.HEIGHT_BITS(HEIGHT_BITS)) u_dwg_checker (.*);

@@ tb/damped_wave_grid_stencil_tb.sv @@
`timescale 1ns / 1ps

module damped_wave_grid_stencil_tb;
    import dwg_pkg::*;

    localparam int          HEIGHT_BITS     = 24;
    localparam int          GRID_MAX        = 256;
    localparam realtime     CLK_PERIOD      = 4.0;
    localparam int unsigned RANDOM_CELLS    = 260;  // the two full frames add 1536 more
    localparam int unsigned SETTLE_CYCLES   = 8;    // pipeline is three deep, leave margin
    localparam int unsigned DRAIN_CYCLES    = 24;
    localparam int unsigned HOLD_OFF_CYCLES = 400;
    localparam longint      TIMEOUT_CYCLES  = 1_000_000;

    // indexes outside the register map; writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 4'd15;

    localparam logic signed [HEIGHT_BITS-1:0] H_MAX = {1'b0, {(HEIGHT_BITS-1){1'b1}}};
    localparam logic signed [HEIGHT_BITS-1:0] H_MIN = {1'b1, {(HEIGHT_BITS-1){1'b0}}};
    localparam longint SAT_HI = (longint'(1) <<< (HEIGHT_BITS - 1)) - 1;
    localparam longint SAT_LO = -(longint'(1) <<< (HEIGHT_BITS - 1));

    // one result transaction as seen on the m_ channel
    typedef struct packed {
        logic [HEIGHT_BITS-1:0] height;
        logic [IDX_W-1:0]       row;
        logic [IDX_W-1:0]       col;
        logic                   run_last;
        logic                   frame_done;
    } wave_out_t;

    typedef enum logic { STEP_REG, STEP_CELL } step_kind_t;

    // directed script row: a register write or a cell; known_n < 0 means the
    // results come from the stencil model, otherwise known[] holds them
    typedef struct {
        step_kind_t                    kind;
        logic [CFG_IDX_W-1:0]          idx;
        logic [CFG_DATA_W-1:0]         val;
        logic signed [HEIGHT_BITS-1:0] cur;
        logic signed [HEIGHT_BITS-1:0] prev;
        int                            known_n;
        wave_out_t                     known[2];
    } script_step_t;

    logic                          aclk;
    logic                          aresetn;
    logic                          s_valid;
    logic                          s_ready;
    logic signed [HEIGHT_BITS-1:0] s_cur_height;
    logic signed [HEIGHT_BITS-1:0] s_prev_height;
    logic                          m_valid;
    logic                          m_ready;
    logic signed [HEIGHT_BITS-1:0] m_next_height;
    logic [IDX_W-1:0]              m_out_row;
    logic [IDX_W-1:0]              m_out_col;
    logic                          m_run_last;
    logic                          m_frame_done;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [CFG_IDX_W-1:0]          cfg_index;
    logic [CFG_DATA_W-1:0]         cfg_data;

    damped_wave_grid_stencil #(
        .MAX_ROWS    (GRID_MAX),
        .MAX_COLS    (GRID_MAX),
        .HEIGHT_BITS (HEIGHT_BITS)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cur_height  (s_cur_height),
        .s_prev_height (s_prev_height),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_next_height (m_next_height),
        .m_out_row     (m_out_row),
        .m_out_col     (m_out_col),
        .m_run_last    (m_run_last),
        .m_frame_done  (m_frame_done),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // ------------------------------------------------------------------
    // Stencil model state: registers, three line stores, raster position
    // and the one-cell window (row-above height of the previous column).
    // ------------------------------------------------------------------
    logic [CFG_SIZE_W-1:0]         rows_reg = ROWS_RESET;
    logic [CFG_SIZE_W-1:0]         cols_reg = COLS_RESET;
    logic [COEF_W-1:0]             keep_reg = KEEP_RESET;
    logic [COEF_W-1:0]             gain_reg = GAIN_RESET;
    logic signed [HEIGHT_BITS-1:0] above_cur  [GRID_MAX] = '{default: '0};
    logic signed [HEIGHT_BITS-1:0] two_above  [GRID_MAX] = '{default: '0};
    logic signed [HEIGHT_BITS-1:0] above_prev [GRID_MAX] = '{default: '0};
    logic signed [HEIGHT_BITS-1:0] left_cell = '0;
    int unsigned                   row_pos = 0;
    int unsigned                   col_pos = 0;

    wave_out_t    due_cells[$];      // next heights still owed by the block
    script_step_t script[$];
    int unsigned  mismatches   = 0;
    bit           no_gaps      = 1'b0;
    bit           hold_off_req = 1'b0;

    // out-of-range sizes clamp to [3, GRID_MAX]
    function automatic int unsigned eff_size(input logic [CFG_SIZE_W-1:0] raw);
        if (raw < MIN_SIZE) return MIN_SIZE;
        if (raw > GRID_MAX) return GRID_MAX;
        return 32'(raw);
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_IDX_ROWS: rows_reg = val[CFG_SIZE_W-1:0];
            CFG_IDX_COLS: cols_reg = val[CFG_SIZE_W-1:0];
            CFG_IDX_KEEP: keep_reg = val[COEF_W-1:0];
            CFG_IDX_GAIN: gain_reg = val[COEF_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic wave_out_t border_cell(input int unsigned r, c, input bit run_last,
                                              input bit frame_done);
        wave_out_t w;
        w            = '0;
        w.row        = IDX_W'(r);
        w.col        = IDX_W'(c);
        w.run_last   = run_last;
        w.frame_done = frame_done;
        return w;
    endfunction

    // Advance the stencil by one cell; returns how many results it causes.
    // The cell at (r, c) releases (r-1, c); on the last row also (r, c).
    function automatic int step_wave_cell(input logic signed [HEIGHT_BITS-1:0] cur, prev,
                                          output wave_out_t first, second);
        int unsigned n_rows, n_cols, r, c;
        bit          on_last_col, on_last_row;
        logic signed [HEIGHT_BITS-1:0] mid;
        longint      two_h, lap, acc;
        int          n;
        n_rows      = eff_size(rows_reg);
        n_cols      = eff_size(cols_reg);
        r           = row_pos;
        c           = col_pos;
        on_last_col = (c >= n_cols - 1);
        on_last_row = (r >= n_rows - 1);
        mid         = above_cur[c];
        first       = '0;
        second      = '0;
        n           = 0;
        if (r > 0) begin
            first = border_cell(r - 1, c, !on_last_row, 1'b0);
            if (r > 1 && c > 0 && !on_last_col) begin
                two_h = 2 * longint'(mid) - longint'(above_prev[c]);
                lap   = longint'(two_above[c]) + longint'(cur) + longint'(left_cell)
                      + longint'(above_cur[c + 1]) - 4 * longint'(mid);
                acc   = longint'(keep_reg) * two_h + longint'(gain_reg) * lap + ROUND_HALF;
                acc   = acc >>> FRAC_SHIFT;     // floor, i.e. round half up
                if (acc > SAT_HI) acc = SAT_HI;
                if (acc < SAT_LO) acc = SAT_LO;
                first.height = acc[HEIGHT_BITS-1:0];
            end
            n = 1;
            if (on_last_row) begin
                second = border_cell(r, c, 1'b1, on_last_col);
                n      = 2;
            end
        end
        two_above[c]  = mid;
        above_cur[c]  = cur;
        above_prev[c] = prev;
        left_cell     = mid;
        if (on_last_col) begin
            col_pos = 0;
            row_pos = on_last_row ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
        end
        return n;
    endfunction

    // ------------------------------------------------------------------
    // Random pickers
    // ------------------------------------------------------------------
    function automatic int unsigned pick_idle();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 50) return 0;
        if (sel < 80) return $urandom_range(1, 2);
        if (sel < 95) return $urandom_range(3, 8);
        return $urandom_range(16, 48);
    endfunction

    function automatic int unsigned pick_ready_run();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 6) return $urandom_range(1, 4);
        if (sel < 9) return $urandom_range(5, 24);
        return $urandom_range(60, 200);
    endfunction

    function automatic logic signed [HEIGHT_BITS-1:0] pick_height();
        logic signed [HEIGHT_BITS-1:0] v;
        int unsigned                   sel;
        v   = HEIGHT_BITS'($urandom());
        sel = $urandom_range(0, 9);
        if (sel < 4) return v >>> $urandom_range(6, 14);   // gentle surface
        if (sel < 8) return v;
        if (sel == 8) return $urandom_range(0, 1) ? H_MAX : H_MIN;
        return $urandom_range(0, 1) ? '0 : '1;
    endfunction

    // mostly small grids; now and then the clamp ranges and the maximum
    function automatic logic [CFG_DATA_W-1:0] pick_size();
        logic [CFG_DATA_W-1:0] v;
        int unsigned           sel;
        sel = $urandom_range(0, 99);
        if (sel < 70)      v = CFG_DATA_W'($urandom_range(3, 10));
        else if (sel < 82) v = CFG_DATA_W'($urandom_range(0, 2));
        else if (sel < 94) v = CFG_DATA_W'($urandom_range(11, 40));
        else if (sel < 97) v = CFG_DATA_W'(GRID_MAX);
        else               v = CFG_DATA_W'($urandom_range(GRID_MAX + 1,
                                                          (1 << CFG_SIZE_W) - 1));
        if ($urandom_range(0, 3) == 0)                    // ignored upper bits
            v[CFG_DATA_W-1:CFG_SIZE_W] = (CFG_DATA_W - CFG_SIZE_W)'($urandom());
        return v;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_coef();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0:       return '0;
            1:       return 16'h8000;
            2:       return CFG_DATA_W'($urandom());      // any value, also above 1.0, used as is
            3, 4, 5: return CFG_DATA_W'($urandom_range(0, 32768));
            default: return CFG_DATA_W'($urandom_range(8000, 32768));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Script builders
    // ------------------------------------------------------------------
    function automatic void add_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
        script_step_t s;
        s         = '{kind: STEP_REG, default: '0};
        s.idx     = idx;
        s.val     = val;
        s.known_n = -1;
        script.insert(script.size(), s);
    endfunction

    function automatic void add_known(input logic signed [HEIGHT_BITS-1:0] cur, prev,
                                      input int known_n, input wave_out_t k0, k1);
        script_step_t s;
        s          = '{kind: STEP_CELL, default: '0};
        s.cur      = cur;
        s.prev     = prev;
        s.known_n  = known_n;
        s.known[0] = k0;
        s.known[1] = k1;
        script.insert(script.size(), s);
    endfunction

    function automatic void add_cell(input logic signed [HEIGHT_BITS-1:0] cur, prev);
        add_known(cur, prev, -1, '0, '0);
    endfunction

    // ------------------------------------------------------------------
    // Drivers. Everything changes on the falling edge; handshakes are
    // sampled on the rising edge.
    // ------------------------------------------------------------------

    // register writes happen only with the block drained
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk) s_valid <= 1'b0;
        while (due_cells.size() != 0) @(negedge aclk);
        // first-row cells owe nothing but may still sit in the pipeline
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        apply_reg(idx, val);
        @(negedge aclk) cfg_valid <= 1'b0;
    endtask

    // queue what the cell owes, then offer it until accepted
    task automatic send_cell(input logic signed [HEIGHT_BITS-1:0] cur, prev,
                             input int known_n, input wave_out_t k0, k1);
        wave_out_t   p0, p1;
        int          n;
        int unsigned gap;
        n = step_wave_cell(cur, prev, p0, p1);
        if (known_n >= 0) begin
            n  = known_n;
            p0 = k0;
            p1 = k1;
        end
        if (n > 0) due_cells.insert(due_cells.size(), p0);
        if (n > 1) due_cells.insert(due_cells.size(), p1);
        gap = no_gaps ? 0 : pick_idle();
        if (gap != 0) begin
            @(negedge aclk) s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid       <= 1'b1;
        s_cur_height  <= cur;
        s_prev_height <= prev;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_random_cell();
        send_cell(pick_height(), pick_height(), -1, '0, '0);
    endtask

    // New settings between bursts. Columns may only grow while the stencil
    // is on row zero, otherwise the line stores would be read unwritten.
    task automatic reconfigure();
        logic [CFG_DATA_W-1:0] v;
        if ($urandom_range(0, 1)) write_reg(CFG_IDX_ROWS, pick_size());
        if ($urandom_range(0, 1)) begin
            v = pick_size();
            if (row_pos != 0 && eff_size(v[CFG_SIZE_W-1:0]) > eff_size(cols_reg))
                v = CFG_DATA_W'($urandom_range(0, eff_size(cols_reg)));
            write_reg(CFG_IDX_COLS, v);
        end
        if ($urandom_range(0, 1)) write_reg(CFG_IDX_KEEP, pick_coef());
        if ($urandom_range(0, 1)) write_reg(CFG_IDX_GAIN, pick_coef());
    endtask

    // One complete frame at a fixed size, starting from a frame boundary.
    // An open frame is closed by dropping to three rows mid-frame.
    task automatic run_full_frame(input int unsigned n_rows, n_cols, input bit squeeze);
        if (row_pos != 0 || col_pos != 0) begin
            write_reg(CFG_IDX_ROWS, CFG_DATA_W'(MIN_SIZE));
            while (row_pos != 0 || col_pos != 0) send_random_cell();
        end
        write_reg(CFG_IDX_ROWS, CFG_DATA_W'(n_rows));
        write_reg(CFG_IDX_COLS, CFG_DATA_W'(n_cols));
        no_gaps = 1'b1;
        // sink stalls for a long stretch while cells keep coming
        if (squeeze) hold_off_req = 1'b1;
        repeat (n_rows * n_cols) send_random_cell();
    endtask

    // ------------------------------------------------------------------
    // Clock and time limit
    // ------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result sink: random ready with short and long gaps, idle-free runs,
    // and one long hold-off on request.
    // ------------------------------------------------------------------
    initial begin : result_sink
        int unsigned run_left, idle_left;
        run_left  = 0;
        idle_left = 0;
        m_ready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                run_left     = 0;
                idle_left    = HOLD_OFF_CYCLES;
            end
            if (run_left == 0 && idle_left == 0) begin
                run_left  = pick_ready_run();
                idle_left = pick_idle();
            end
            if (run_left != 0) begin
                run_left--;
                m_ready <= 1'b1;
            end else begin
                idle_left--;
                m_ready <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Checker: every result transaction against the oldest owed height
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        wave_out_t owed;
        if (aresetn && m_valid && m_ready) begin
            if (due_cells.size() == 0) begin
                $error("unexpected result: row %0d col %0d height %0d",
                       m_out_row, m_out_col, m_next_height);
                mismatches++;
            end else begin
                owed = due_cells.pop_front();
                if (m_next_height !== owed.height) begin
                    $error("next_height: expected %0d, got %0d",
                           $signed(owed.height), m_next_height);
                    mismatches++;
                end
                if (m_out_row !== owed.row) begin
                    $error("out_row: expected %0d, got %0d", owed.row, m_out_row);
                    mismatches++;
                end
                if (m_out_col !== owed.col) begin
                    $error("out_col: expected %0d, got %0d", owed.col, m_out_col);
                    mismatches++;
                end
                if (m_run_last !== owed.run_last) begin
                    $error("run_last: expected %0b, got %0b", owed.run_last, m_run_last);
                    mismatches++;
                end
                if (m_frame_done !== owed.frame_done) begin
                    $error("frame_done: expected %0b, got %0b",
                           owed.frame_done, m_frame_done);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        int unsigned random_cells, burst;
        bit          wide_done, tall_done;

        s_valid       = 1'b0;
        s_cur_height  = '0;
        s_prev_height = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        aresetn       = 1'b0;
        random_cells  = 0;
        wide_done     = 1'b0;
        tall_done     = 1'b0;

        // Directed frame 1: two row-zero cells under the reset size, then the
        // grid shrinks to 3x3 with the column counter already on the new last
        // index, so row zero ends at the next cell. Full coefficients.
        add_known(H_MAX, H_MIN, 0, '0, '0);
        add_known(H_MIN, H_MAX, 0, '0, '0);
        add_reg(CFG_IDX_ROWS, 16'd3);
        add_reg(CFG_IDX_COLS, 16'd3);
        add_reg(CFG_IDX_KEEP, 16'h8000);
        add_reg(CFG_IDX_GAIN, 16'h8000);
        add_known('0, '0, 0, '0, '0);
        // row one releases row zero: all border
        add_known(H_MIN, 24'sh000001, 1, border_cell(0, 0, 1'b1, 1'b0), '0);
        add_known(H_MAX, H_MIN,       1, border_cell(0, 1, 1'b1, 1'b0), '0);
        add_known(H_MIN, 24'sh7FF000, 1, border_cell(0, 2, 1'b1, 1'b0), '0);
        // last row gives two results per cell; the interior cell is modelled
        add_known(H_MIN, '0, 2, border_cell(1, 0, 1'b0, 1'b0),
                  border_cell(2, 0, 1'b1, 1'b0));
        add_cell(H_MIN, H_MAX);
        add_known(H_MIN, '0, 2, border_cell(1, 2, 1'b0, 1'b0),
                  border_cell(2, 2, 1'b1, 1'b1));

        // Directed frame 2: no damping term, gain above one, sizes below the
        // minimum (upper data bits set on rows), writes to unmapped indexes.
        add_reg(CFG_IDX_KEEP, 16'h0000);
        add_reg(CFG_IDX_GAIN, 16'hFFFF);
        add_reg(CFG_IDX_ROWS, 16'hFE00);
        add_reg(CFG_IDX_COLS, 16'h0002);
        add_reg(CFG_IDX_SPARE_LO, 16'hFFFF);
        add_reg(CFG_IDX_SPARE_HI, 16'hFFFF);
        add_cell('0,    24'sh5A5A5A);
        add_cell(H_MAX, '1);
        add_cell('0,    24'sh5A5A5A);
        add_cell(H_MAX, H_MIN);
        add_cell(H_MIN, H_MAX);          // sunken center pulled up to saturation
        add_cell(H_MAX, '0);
        add_cell('0,    '1);
        add_cell(H_MAX, 24'shA5A5A5);
        add_cell('0,    '0);

        repeat (10) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        foreach (script[i]) begin
            if (script[i].kind == STEP_REG)
                write_reg(script[i].idx, script[i].val);
            else
                send_cell(script[i].cur, script[i].prev, script[i].known_n,
                          script[i].known[0], script[i].known[1]);
        end

        // Random bursts under changing settings. Two full frames reach the
        // last column and the last row index; the tall one also carries
        // the long sink hold-off.
        while (random_cells < RANDOM_CELLS) begin
            if (!wide_done && random_cells >= RANDOM_CELLS / 3) begin
                run_full_frame(MIN_SIZE, GRID_MAX, 1'b0);
                wide_done = 1'b1;
            end
            if (!tall_done && random_cells >= 2 * RANDOM_CELLS / 3) begin
                run_full_frame(GRID_MAX, MIN_SIZE, 1'b1);
                tall_done = 1'b1;
            end
            reconfigure();
            no_gaps = ($urandom_range(0, 3) == 0);
            burst   = $urandom_range(1, 80);
            repeat (burst) send_random_cell();
            random_cells += burst;
        end

        @(negedge aclk) s_valid <= 1'b0;
        while (due_cells.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ filelist.f @@
src/dwg_pkg.sv
src/dwg_line_store.sv
src/dwg_stencil_calc.sv
src/dwg_result_fifo.sv
src/damped_wave_grid_stencil.sv
src/dwg_checker.sv
tb/damped_wave_grid_stencil_tb.sv
